[hw/rtl/wildcard_byte_pattern_scan_defines.svh]
// Assertion macros for the wildcard byte pattern scanner.
// Used by the checker module; no other dependencies.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WBPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wbps assertion failed");

// Next-cycle implication, disabled during reset.
`define WBPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbps assertion failed");

`endif

[hw/rtl/wbps_pkg.sv]
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies.
package wbps_pkg;

  localparam int PATTERN_BYTES = 16;
  localparam int LEN_IDX_W     = 4;
  localparam int CFG_IDX_W     = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PATTERN_LOW  = cfg_index_t'(0);
  localparam cfg_index_t REG_PATTERN_HIGH = cfg_index_t'(1);
  localparam cfg_index_t REG_PATTERN_LEN  = cfg_index_t'(2);
  localparam cfg_index_t REG_BASE_ADDR    = cfg_index_t'(3);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } scan_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
    logic        region_done;
  } result_word_t;

  typedef struct packed {
    cfg_index_t  index;
    logic [63:0] value;
  } cfg_word_t;

endpackage

[hw/rtl/wbps_chan_if.sv]
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from wbps_pkg at the instance.
interface wbps_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/wbps_cell.sv]
// One window position: holds a byte, passes it on, and compares the byte
// it is about to hold against its pattern byte. Uses wbps_pkg.
module wbps_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  logic                             shift,
  input  logic [7:0]                       data_in,
  input  logic [7:0]                       pattern [wbps_pkg::PATTERN_BYTES],
  input  logic [wbps_pkg::LEN_IDX_W-1:0]   len_m1,
  output logic [7:0]                       held,
  output logic                             hit
);

  localparam logic [wbps_pkg::LEN_IDX_W-1:0] POS = wbps_pkg::LEN_IDX_W'(INDEX);

  logic                              active;
  logic [wbps_pkg::LEN_IDX_W-1:0]    sel;
  logic [7:0]                        pat;

  // window[k] lines up with pattern byte len-1-k
  assign active = (POS <= len_m1);
  assign sel    = len_m1 - POS;
  assign pat    = pattern[sel];
  assign hit    = !active || (pat == 8'd0) || (pat == data_in);

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= data_in;
    end
  end

endmodule

[hw/rtl/wildcard_byte_pattern_scan.sv]
// Wildcard byte pattern scanner, top level. Uses wbps_pkg, wbps_chan_if and
// wbps_cell.
// Takes one byte per clock with no gaps of its own: a row of MAX_PATTERN cells
// shifts the window and compares every position against the pattern in the
// same cycle as the byte is accepted, so the compare row sets the rate of one
// byte per cycle. The region's result appears in the output register on the
// cycle after its last byte is accepted when that register is free; otherwise
// it waits in a skid register behind it until the output word is taken. The
// skid register lets the scan keep going while a result waits; the scan side
// stalls only when both hold results. A pattern byte of zero matches anything.
// Only the first match of a region is reported, as base_address plus the
// offset of the match start; a region with no match reports all ones.
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN = 16
) (
  input logic        clk,
  input logic        rst,
  wbps_chan_if.sink   scan,
  wbps_chan_if.source result,
  wbps_chan_if.sink   cfg
);

  localparam int LW = wbps_pkg::LEN_IDX_W;

  // configuration
  logic [63:0]   pattern_low;
  logic [63:0]   pattern_high;
  logic [LW-1:0] len_m1;
  logic [31:0]   base_address;

  // scan state
  logic [31:0] bytes_seen;
  logic        match_seen;
  logic [31:0] first_address;

  // output register and skid
  logic                   out_valid;
  wbps_pkg::result_word_t out_word;
  logic                   skid_valid;
  wbps_pkg::result_word_t skid_word;

  logic [7:0]          pat_bytes [wbps_pkg::PATTERN_BYTES];
  logic [7:0]          win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  logic                   accept;
  logic                   new_result;
  logic [31:0]            bytes_next;
  logic [31:0]            len_full;
  logic                   hit_now;
  logic [31:0]            addr_now;
  wbps_pkg::result_word_t res_next;
  logic [4:0]             len_wr;

  assign cfg.ready   = 1'b1;
  assign scan.ready  = !skid_valid;
  assign accept      = scan.valid && scan.ready;
  assign new_result  = accept && scan.data.last_byte;

  always_comb begin
    for (int b = 0; b < wbps_pkg::PATTERN_BYTES; b++) begin
      if (b < 8) begin
        pat_bytes[b] = pattern_low[b*8 +: 8];
      end else begin
        pat_bytes[b] = pattern_high[(b-8)*8 +: 8];
      end
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] feed;
    if (k == 0) begin : g_head
      assign feed = scan.data.data_byte;
    end else begin : g_body
      assign feed = win[k-1];
    end
    wbps_cell #(.INDEX(k)) u_cell (
      .clk     (clk),
      .shift   (accept),
      .data_in (feed),
      .pattern (pat_bytes),
      .len_m1  (len_m1),
      .held    (win[k]),
      .hit     (hit[k])
    );
  end

  assign bytes_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + 32'd1;
  assign len_full   = 32'(len_m1) + 32'd1;
  assign hit_now    = !match_seen && (&hit) && (bytes_next >= len_full);
  assign addr_now   = base_address + bytes_next - len_full;

  always_comb begin
    res_next.found         = match_seen || hit_now;
    res_next.match_address = match_seen ? first_address : (hit_now ? addr_now : '1);
    res_next.region_done   = 1'b1;
  end

  // configuration writes; length is stored already clamped
  assign len_wr = cfg.data.value[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      len_m1       <= '0;
      base_address <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.index)
        wbps_pkg::REG_PATTERN_LOW:  pattern_low  <= cfg.data.value;
        wbps_pkg::REG_PATTERN_HIGH: pattern_high <= cfg.data.value;
        wbps_pkg::REG_PATTERN_LEN: begin
          if (len_wr == 5'd0) begin
            len_m1 <= '0;
          end else if (len_wr > 5'(MAX_PATTERN)) begin
            len_m1 <= LW'(MAX_PATTERN - 1);
          end else begin
            len_m1 <= LW'(len_wr - 5'd1);
          end
        end
        wbps_pkg::REG_BASE_ADDR:    base_address <= cfg.data.value[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      match_seen    <= 1'b0;
      first_address <= '1;
    end else if (accept) begin
      if (scan.data.last_byte) begin
        bytes_seen    <= '0;
        match_seen    <= 1'b0;
        first_address <= '1;
      end else begin
        bytes_seen <= bytes_next;
        if (hit_now) begin
          match_seen    <= 1'b1;
          first_address <= addr_now;
        end
      end
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid  <= skid_valid || new_result;
      skid_valid <= 1'b0;
    end else if (new_result) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (new_result) begin
        out_word <= res_next;
      end
    end else if (new_result) begin
      skid_word <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_word;

endmodule

[hw/rtl/wbps_checker.sv]
// Port-level checks for the wildcard byte pattern scanner, bound to the top.
// Uses wildcard_byte_pattern_scan_defines.svh.
`include "wildcard_byte_pattern_scan_defines.svh"

module wbps_checker (
  input logic        clk,
  input logic        rst,
  input logic        scan_valid,
  input logic        scan_ready,
  input logic        scan_last,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_found,
  input logic [31:0] res_address,
  input logic        res_done
);

  // a stalled result word keeps its value
  `WBPS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_address) && $stable(res_found))

  // a new result only follows a last byte
  `WBPS_ASSERT_SAME(a_res_after_last, clk, rst, $rose(res_valid), $past(scan_valid && scan_ready && scan_last))

  // no match means the address reads all ones
  `WBPS_ASSERT_SAME(a_miss_addr, clk, rst, res_valid && !res_found, res_address == 32'hFFFF_FFFF)

  `WBPS_ASSERT_SAME(a_done_set, clk, rst, res_valid, res_done)

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
  .clk         (clk),
  .rst         (rst),
  .scan_valid  (scan.valid),
  .scan_ready  (scan.ready),
  .scan_last   (scan.data.last_byte),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_found   (result.data.found),
  .res_address (result.data.match_address),
  .res_done    (result.data.region_done)
);

[test/testbench.sv]
// Self-checking testbench for wildcard_byte_pattern_scan.
// Needs wbps_pkg, wbps_chan_if and the scanner RTL; a scoreboard class predicts
// each region's outcome and plain tasks drive the scan and config channels.

class pattern_scoreboard;
  logic [127:0] pat;
  logic [4:0]   pat_len;
  logic [31:0]  base;
  logic [7:0]   win [16];
  logic [31:0]  seen;
  bit           hit;
  logic [31:0]  hit_addr;
  wbps_pkg::result_word_t outcomes [$];
  int           errors;

  function new();
    pat     = '0;
    pat_len = 5'd1;
    base    = '0;
    errors  = 0;
    clear_region();
  endfunction

  function void clear_region();
    foreach (win[i]) win[i] = 8'h00;
    seen     = '0;
    hit      = 1'b0;
    hit_addr = '1;
  endfunction

  function int unsigned eff_len();
    int unsigned n;
    n = pat_len;
    if (n < 1) n = 1;
    if (n > wbps_pkg::PATTERN_BYTES) n = wbps_pkg::PATTERN_BYTES;
    return n;
  endfunction

  function void write_reg(wbps_pkg::cfg_index_t idx, logic [63:0] v);
    case (idx)
      wbps_pkg::REG_PATTERN_LOW:  pat[63:0]   = v;
      wbps_pkg::REG_PATTERN_HIGH: pat[127:64] = v;
      wbps_pkg::REG_PATTERN_LEN:  pat_len     = v[4:0];
      wbps_pkg::REG_BASE_ADDR:    base        = v[31:0];
      default: ;
    endcase
  endfunction

  function void scan_byte(wbps_pkg::scan_word_t w);
    int unsigned            n;
    bit                     ok;
    logic [7:0]             p;
    wbps_pkg::result_word_t r;
    n = eff_len();
    for (int i = 15; i > 0; i--) win[i] = win[i-1];
    win[0] = w.data_byte;
    // saturation needs 4G bytes in one region, far beyond any run here
    if (seen != 32'hFFFF_FFFF) seen++;
    if (!hit && seen >= n) begin
      ok = 1'b1;
      // pattern byte 0 lines up with the oldest byte of the window
      for (int i = 0; i < n; i++) begin
        p = pat[i*8 +: 8];
        if (p != 8'h00 && p != win[n-1-i]) ok = 1'b0;
      end
      if (ok) begin
        hit      = 1'b1;
        hit_addr = base + (seen - n);
      end
    end
    if (w.last_byte) begin
      r.found         = hit;
      r.match_address = hit ? hit_addr : 32'hFFFF_FFFF;
      r.region_done   = 1'b1;
      outcomes = {outcomes, r};
      clear_region();
    end
  endfunction

  function void check_outcome(wbps_pkg::result_word_t got);
    wbps_pkg::result_word_t want;
    if (outcomes.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: found=%0d addr=%h done=%0d",
                 got.found, got.match_address, got.region_done);
      return;
    end
    want = outcomes.pop_front();
    if (got.found !== want.found || got.match_address !== want.match_address ||
        got.region_done !== want.region_done) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected found=%0d addr=%h done=%0d, got found=%0d addr=%h done=%0d",
                 want.found, want.match_address, want.region_done,
                 got.found, got.match_address, got.region_done);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {RX_HOLD, RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  wbps_chan_if #(.payload_t(wbps_pkg::scan_word_t))   scan_ch ();
  wbps_chan_if #(.payload_t(wbps_pkg::result_word_t)) result_ch ();
  wbps_chan_if #(.payload_t(wbps_pkg::cfg_word_t))    cfg_ch ();

  wildcard_byte_pattern_scan #(.MAX_PATTERN(16)) DUT (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  pattern_scoreboard sb = new();

  int bytes_sent  = 0;
  int burst_left  = 0;
  bit squeeze_req = 1'b0;

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input bit last);
    int                   gap;
    wbps_pkg::scan_word_t w;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        scan_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    w.data_byte = d;
    w.last_byte = last;
    scan_ch.valid <= 1'b1;
    scan_ch.data  <= w;
    do @(posedge clk); while (!scan_ch.ready);
    sb.scan_byte(w);
    bytes_sent++;
  endtask

  // valid stays high; the caller lowers it once the batch is done
  task automatic write_reg(input wbps_pkg::cfg_index_t idx, input logic [63:0] v);
    wbps_pkg::cfg_word_t c;
    c.index = idx;
    c.value = v;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, v);
  endtask

  task automatic settle();
    scan_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_config();
    logic [127:0] p;
    logic [63:0]  v;
    int           k;
    int           len;
    k = $urandom_range(0, 9);
    for (int j = 0; j < 16; j++) begin
      if (k == 0) p[j*8 +: 8] = 8'hFF;
      else if (k == 1) p[j*8 +: 8] = 8'h00;
      else if ($urandom_range(0, 3) == 0) p[j*8 +: 8] = 8'h00;
      else p[j*8 +: 8] = 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 3) != 0) write_reg(wbps_pkg::REG_PATTERN_LOW, p[63:0]);
    if ($urandom_range(0, 3) != 0) write_reg(wbps_pkg::REG_PATTERN_HIGH, p[127:64]);
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = 1;
      2:       len = 16;
      3:       len = $urandom_range(17, 31);
      default: len = $urandom_range(1, 16);
    endcase
    v = {$urandom, $urandom};
    v[4:0] = 5'(len);
    if ($urandom_range(0, 3) != 0) write_reg(wbps_pkg::REG_PATTERN_LEN, v);
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       v[31:0] = 32'h0000_0000;
      1:       v[31:0] = 32'hFFFF_FFFF;
      2:       v[31:0] = 32'hFFFF_FFF0;
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(wbps_pkg::REG_BASE_ADDR, v);
    if ($urandom_range(0, 4) == 0)
      write_reg(wbps_pkg::cfg_index_t'($urandom_range(4, 255)), {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly plants the pattern at a random offset, wildcards filled at random
  task automatic send_region(input int n, input bit close);
    int          at;
    int unsigned plen;
    logic [7:0]  b;
    logic [7:0]  p;
    plen = sb.eff_len();
    at = (n >= plen && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - plen) : -1;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      if (at >= 0 && k >= at && k < at + plen) begin
        p = sb.pat[(k-at)*8 +: 8];
        if (p != 8'h00) b = p;
      end
      send_byte(b, close && (k == n - 1));
    end
  endtask

  task automatic run_phase(input int phase_no);
    int nreg;
    int n;
    bit squeeze;
    settle();
    pick_config();
    squeeze = (phase_no == 2);
    nreg = squeeze ? 10 : $urandom_range(1, 5);
    if (squeeze) squeeze_req = 1'b1;
    for (int r = 0; r < nreg; r++) begin
      if (squeeze) n = $urandom_range(2, 10);
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 60);
      else n = $urandom_range(1, sb.eff_len() + 8);
      // an open tail carries the region across the next config change
      send_region(n, squeeze || r < nreg - 1 || $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin : result_side
    rx_mode_t mode;
    int       left;
    bit       squeezed;
    mode = RX_OPEN;
    left = 0;
    squeezed = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) sb.check_outcome(result_ch.data);
      if (squeeze_req && !squeezed) begin
        // long hold so results pile up and the scan side backs off
        squeezed = 1'b1;
        mode = RX_HOLD;
        left = 300;
      end else if (left == 0) begin
        mode = rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        RX_HOLD:   result_ch.ready <= 1'b0;
        RX_OPEN:   result_ch.ready <= 1'b1;
        RX_HALF:   result_ch.ready <= $urandom_range(0, 1);
        RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    int phase_no;
    rst           <= 1'b1;
    scan_ch.valid <= 1'b0;
    scan_ch.data  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pattern: one wildcard byte, every byte matches at offset zero
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    // full-length pattern, base near the top so the address wraps
    settle();
    write_reg(wbps_pkg::REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(wbps_pkg::REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd16);
    write_reg(wbps_pkg::REG_BASE_ADDR, 64'hFFFF_FFFF_FFFF_FFF8);
    cfg_ch.valid <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 16; i++) send_byte(8'hFF, i == 15);

    // length zero acts as one; the second match must not replace the first
    settle();
    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
    write_reg(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_00AB);
    write_reg(wbps_pkg::REG_BASE_ADDR, 64'd0);
    write_reg(wbps_pkg::cfg_index_t'(255), 64'hDEAD_BEEF_0123_4567);
    cfg_ch.valid <= 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hAB, 1'b1);

    phase_no = 0;
    while (bytes_sent < 600) begin
      run_phase(phase_no);
      phase_no++;
    end

    scan_ch.valid <= 1'b0;
    while (sb.outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
